// ===== src/fsin_pkg.sv =====
package fsin_pkg;

   localparam logic [31:0] INV_PI    = 32'h3EA2_F983;
   localparam logic [31:0] PI_A      = 32'h4049_0FDB;
   localparam logic [31:0] PI_B      = 32'hB3BB_BD2E;
   localparam logic [31:0] PI_C      = 32'hA777_2CED;
   localparam logic [31:0] COEF0     = 32'hBE2A_AAA7;
   localparam logic [31:0] COEF1     = 32'h3C08_8791;
   localparam logic [31:0] COEF2     = 32'hB94F_BE6B;
   localparam logic [31:0] COEF3     = 32'h362F_31B2;
   localparam logic [31:0] BIG_ARG   = 32'h4980_0000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
   localparam logic [31:0] QNAN      = 32'h7FC0_0000;

   // side data that travels alongside each item through the arithmetic units
   typedef struct packed {
      logic        sx;
      logic        big;
      logic        n_odd;
      logic [31:0] neg_nf;
      logic [31:0] ax;
      logic [31:0] r;
      logic [31:0] rr;
      logic [31:0] rrr;
   } fsin_tag_type;

   function automatic logic [4:0] lzc20(input logic [19:0] v);
      logic [4:0] cnt;
      cnt = 5'd20;
      for (int i = 0; i < 20; i++) begin
         if (v[i]) cnt = 5'(19 - i);
      end
      return cnt;
   endfunction

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] cnt;
      cnt = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) cnt = 5'(23 - i);
      end
      return cnt;
   endfunction

   function automatic logic [6:0] lzc77(input logic [76:0] v);
      logic [6:0] cnt;
      cnt = 7'd77;
      for (int i = 0; i < 77; i++) begin
         if (v[i]) cnt = 7'(76 - i);
      end
      return cnt;
   endfunction

endpackage

// ===== src/fsin_chan_if.sv =====
interface fsin_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] arg_bits;

   modport source (output valid, output arg_bits, input ready);
   modport sink   (input valid, input arg_bits, output ready);
endinterface

interface fsin_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sine_bits;

   modport source (output valid, output sine_bits, input ready);
   modport sink   (input valid, input sine_bits, output ready);
endinterface

// ===== src/fsin_fma.sv =====
module fsin_fma (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [31:0]           in_a,
   input  logic [31:0]           in_b,
   input  logic [31:0]           in_c,
   input  fsin_pkg::fsin_tag_type in_tag,
   output logic                  out_valid,
   output logic [31:0]           out_res,
   output fsin_pkg::fsin_tag_type out_tag
);
   import fsin_pkg::*;

   // a + b*c, one rounding to nearest even; six stages
   typedef struct packed {
      logic               sign;
      logic               zero;
      logic [23:0]        mant;
      logic signed [11:0] lsb;
   } fsin_op_type;

   function automatic fsin_op_type unpack(input logic [31:0] f);
      fsin_op_type o;
      logic [4:0]  lz;
      lz     = lzc24({1'b0, f[22:0]});
      o.sign = f[31];
      o.zero = (f[30:0] == 31'd0);
      if (f[30:23] == 8'd0) begin
         o.mant = {1'b0, f[22:0]} << lz;
         o.lsb  = -12'sd149 - $signed({7'd0, lz});
      end else begin
         o.mant = {1'b1, f[22:0]};
         o.lsb  = $signed({4'd0, f[30:23]}) - 12'sd150;
      end
      return o;
   endfunction

   // stage 1
   logic         v1_ff;
   fsin_op_type  a1_ff, b1_ff, c1_ff;
   fsin_tag_type t1_ff;

   // stage 2
   logic               v2_ff;
   logic [47:0]        prod2_ff, prod2_in;
   logic signed [11:0] lp2_ff, lp2_in;
   logic signed [11:0] sh2_ff, sh2_in;
   logic               sp2_ff, pz2_ff;
   fsin_op_type        a2_ff;
   fsin_tag_type       t2_ff;

   // stage 3
   logic               v3_ff;
   logic [75:0]        aw3_ff, aw3_in, pw3_ff, pw3_in;
   logic signed [11:0] lw3_ff, lw3_in;
   logic               sa3_ff, sp3_ff, sub3_ff;
   fsin_tag_type       t3_ff;

   // stage 4
   logic               v4_ff;
   logic [76:0]        m4_ff, m4_in;
   logic               sg4_ff, sg4_in, z4_ff, z4_in;
   logic signed [11:0] lw4_ff;
   fsin_tag_type       t4_ff;

   // stage 5
   logic               v5_ff;
   logic [76:0]        mn5_ff, mn5_in;
   logic signed [11:0] be5_ff, be5_in;
   logic               sg5_ff, z5_ff;
   fsin_tag_type       t5_ff;

   // stage 6
   logic               v6_ff;
   logic [31:0]        res6_ff, res6_in;
   fsin_tag_type       t6_ff;

   always_comb begin
      prod2_in = 48'(b1_ff.mant) * 48'(c1_ff.mant);
      lp2_in   = $signed(b1_ff.lsb) + $signed(c1_ff.lsb);
      sh2_in   = lp2_in - $signed(a1_ff.lsb) + 12'sd50;
   end

   // alignment: addend far above the product leaves the product as a sticky bit
   logic         top3;
   logic [6:0]   shc3;
   logic [151:0] ext3;
   always_comb begin
      top3 = pz2_ff || (!a2_ff.zero && (sh2_ff < 12'sd0));
      shc3 = (sh2_ff > 12'sd127) ? 7'd127 : sh2_ff[6:0];
      ext3 = {a2_ff.mant, 128'd0} >> shc3;
      if (top3) begin
         aw3_in = {a2_ff.mant, 52'd0};
         pw3_in = {75'd0, !pz2_ff};
         lw3_in = $signed(a2_ff.lsb) - 12'sd52;
      end else begin
         aw3_in = a2_ff.zero ? 76'd0 : {ext3[151:77], ext3[76] | (|ext3[75:0])};
         pw3_in = {26'd0, prod2_ff, 2'b00};
         lw3_in = lp2_ff - 12'sd2;
      end
   end

   logic [76:0] sum4, dpa4, dap4;
   always_comb begin
      sum4 = {1'b0, aw3_ff} + {1'b0, pw3_ff};
      dpa4 = {1'b0, pw3_ff} - {1'b0, aw3_ff};
      dap4 = {1'b0, aw3_ff} - {1'b0, pw3_ff};
      if (!sub3_ff) begin
         m4_in  = sum4;
         sg4_in = sa3_ff;
      end else if (pw3_ff >= aw3_ff) begin
         m4_in  = dpa4;
         sg4_in = sp3_ff;
      end else begin
         m4_in  = dap4;
         sg4_in = sa3_ff;
      end
      z4_in = (m4_in == 77'd0);
      // exact cancellation gives +0
      if (z4_in) sg4_in = sub3_ff ? 1'b0 : sa3_ff;
   end

   logic [6:0] lz5;
   always_comb begin
      lz5    = lzc77(m4_ff);
      mn5_in = m4_ff << lz5;
      be5_in = lw4_ff + 12'sd203 - $signed({5'd0, lz5});
   end

   logic signed [11:0] omb6;
   logic [4:0]         ds6;
   logic [76:0]        mask6, ms6;
   logic               lost6, g6, st6, inc6;
   logic [7:0]         expf6;
   logic [30:0]        mag6;
   always_comb begin
      omb6  = 12'sd1 - be5_ff;
      if (be5_ff > 12'sd0) ds6 = 5'd0;
      else ds6 = (omb6 > 12'sd31) ? 5'd31 : omb6[4:0];
      mask6 = (77'd1 << ds6) - 77'd1;
      lost6 = |(mn5_ff & mask6);
      ms6   = mn5_ff >> ds6;
      expf6 = (be5_ff > 12'sd0) ? be5_ff[7:0] : 8'd0;
      g6    = ms6[52];
      st6   = (|ms6[51:0]) | lost6;
      inc6  = g6 & (st6 | ms6[53]);
      mag6  = {expf6, ms6[75:53]} + 31'(inc6);
      if (z5_ff) res6_in = {sg5_ff, 31'd0};
      else if (be5_ff >= 12'sd255) res6_in = {sg5_ff, 8'hFF, 23'd0};
      else res6_in = {sg5_ff, mag6};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= unpack(in_a);
         b1_ff    <= unpack(in_b);
         c1_ff    <= unpack(in_c);
         t1_ff    <= in_tag;
         prod2_ff <= prod2_in;
         lp2_ff   <= lp2_in;
         sh2_ff   <= sh2_in;
         sp2_ff   <= b1_ff.sign ^ c1_ff.sign;
         pz2_ff   <= b1_ff.zero | c1_ff.zero;
         a2_ff    <= a1_ff;
         t2_ff    <= t1_ff;
         aw3_ff   <= aw3_in;
         pw3_ff   <= pw3_in;
         lw3_ff   <= lw3_in;
         sa3_ff   <= a2_ff.sign;
         sp3_ff   <= sp2_ff;
         sub3_ff  <= a2_ff.sign ^ sp2_ff;
         t3_ff    <= t2_ff;
         m4_ff    <= m4_in;
         sg4_ff   <= sg4_in;
         z4_ff    <= z4_in;
         lw4_ff   <= lw3_ff;
         t4_ff    <= t3_ff;
         mn5_ff   <= mn5_in;
         be5_ff   <= be5_in;
         sg5_ff   <= sg4_ff;
         z5_ff    <= z4_ff;
         t5_ff    <= t4_ff;
         res6_ff  <= res6_in;
         t6_ff    <= t5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_res   = res6_ff;
   assign out_tag   = t6_ff;

endmodule

// ===== src/fsin_rnd.sv =====
module fsin_rnd (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [31:0]           in_q,
   input  fsin_pkg::fsin_tag_type in_tag,
   output logic                  out_valid,
   output fsin_pkg::fsin_tag_type out_tag
);
   import fsin_pkg::*;

   // q rounded half-even to an integer n, then -n as a float
   logic         va_ff;
   logic [19:0]  na_ff, na_in;
   fsin_tag_type ta_ff;
   logic         vb_ff;
   fsin_tag_type tb_ff, tb_in;

   logic [7:0]  ea;
   logic [23:0] ma, ipa;
   logic        small_a;
   logic [4:0]  sa;
   logic [48:0] exta;
   logic        inca;
   always_comb begin
      ea      = in_q[30:23];
      ma      = {|ea, in_q[22:0]};
      small_a = (ea < 8'd126);
      sa      = 5'(8'd150 - ea);
      exta    = {ma, 25'd0} >> sa;
      ipa     = exta[48:25];
      inca    = exta[24] & ((|exta[23:0]) | ipa[0]);
      na_in   = small_a ? 20'd0 : 20'(ipa + 24'(inca));
   end

   logic [4:0]  lzb;
   logic [19:0] nnb;
   logic [7:0]  expb;
   always_comb begin
      lzb   = lzc20(na_ff);
      nnb   = na_ff << lzb;
      expb  = 8'd146 - {3'd0, lzb};
      tb_in = ta_ff;
      tb_in.n_odd  = na_ff[0];
      tb_in.neg_nf = (na_ff == 20'd0) ? NEG_ZERO : {1'b1, expb, nnb[18:0], 4'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         na_ff <= na_in;
         ta_ff <= in_tag;
         tb_ff <= tb_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_tag   = tb_ff;

endmodule

// ===== src/float32_sine_unit.sv =====
// A request passes through the arithmetic pipeline and is then captured in the response
// register, which loads while empty or while its response is being taken.
// Throughput: one item per cycle when not stalled by a held response; nine six-stage
// fused multiply-add units in a row plus a two-stage integer rounding step set the depth.
// A held response does not stop intake while the last stage is empty.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module float32_sine_unit (
   input logic       clock,
   input logic       reset,
   fsin_req_if.sink  req_chan,
   fsin_rsp_if.source rsp_chan
);
   import fsin_pkg::*;

   logic adv;
   logic load_out;

   logic         v0, vn, v1, v2, v3, v4, v5, v6, v7, v8, v9;
   logic [31:0]  q0, r1, r2, r3, rr4, rrr5, y6, y7, y8, y9;
   fsin_tag_type tag0, tq, tn, to1, to2, to3, tag4, to4, tag5, to6, tag7, to7, to8, to9;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_bits_ff, rsp_bits_in;

   assign adv            = !v9 || !rsp_valid_ff || rsp_chan.ready;
   assign load_out       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      tag0     = '0;
      tag0.sx  = req_chan.arg_bits[31];
      tag0.big = (req_chan.arg_bits[30:0] >= BIG_ARG[30:0]);
      tag0.ax  = {1'b0, req_chan.arg_bits[30:0]};
   end

   fsin_fma u_mul_q (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_chan.valid), .in_a(NEG_ZERO), .in_b(tag0.ax), .in_c(INV_PI),
      .in_tag(tag0), .out_valid(v0), .out_res(q0), .out_tag(tq)
   );

   fsin_rnd u_rnd (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v0), .in_q(q0), .in_tag(tq), .out_valid(vn), .out_tag(tn)
   );

   fsin_fma u_red_a (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(vn), .in_a(tn.ax), .in_b(tn.neg_nf), .in_c(PI_A),
      .in_tag(tn), .out_valid(v1), .out_res(r1), .out_tag(to1)
   );

   fsin_fma u_red_b (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v1), .in_a(r1), .in_b(to1.neg_nf), .in_c(PI_B),
      .in_tag(to1), .out_valid(v2), .out_res(r2), .out_tag(to2)
   );

   fsin_fma u_red_c (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v2), .in_a(r2), .in_b(to2.neg_nf), .in_c(PI_C),
      .in_tag(to2), .out_valid(v3), .out_res(r3), .out_tag(to3)
   );

   always_comb begin
      tag4   = to3;
      tag4.r = r3;
   end

   fsin_fma u_sq (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v3), .in_a(NEG_ZERO), .in_b(r3), .in_c(r3),
      .in_tag(tag4), .out_valid(v4), .out_res(rr4), .out_tag(to4)
   );

   always_comb begin
      tag5    = to4;
      tag5.rr = rr4;
   end

   // cube and first Horner step run side by side
   fsin_fma u_cube (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v4), .in_a(NEG_ZERO), .in_b(rr4), .in_c(to4.r),
      .in_tag(tag5), .out_valid(v5), .out_res(rrr5), .out_tag()
   );

   fsin_fma u_poly_2 (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v4), .in_a(COEF2), .in_b(rr4), .in_c(COEF3),
      .in_tag(tag5), .out_valid(v6), .out_res(y6), .out_tag(to6)
   );

   always_comb begin
      tag7     = to6;
      tag7.rrr = rrr5;
   end

   fsin_fma u_poly_1 (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v6 && v5), .in_a(COEF1), .in_b(to6.rr), .in_c(y6),
      .in_tag(tag7), .out_valid(v7), .out_res(y7), .out_tag(to7)
   );

   fsin_fma u_poly_0 (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v7), .in_a(COEF0), .in_b(to7.rr), .in_c(y7),
      .in_tag(to7), .out_valid(v8), .out_res(y8), .out_tag(to8)
   );

   fsin_fma u_poly_r (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v8), .in_a(to8.r), .in_b(to8.rrr), .in_c(y8),
      .in_tag(to8), .out_valid(v9), .out_res(y9), .out_tag(to9)
   );

   always_comb begin
      rsp_valid_in = load_out ? v9 : rsp_valid_ff;
      if (to9.big) rsp_bits_in = QNAN;
      else rsp_bits_in = y9 ^ ({to9.n_odd ^ to9.sx, 31'd0} & SIGN_MASK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out && v9) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.sine_bits = rsp_bits_ff;

endmodule

// ===== src/fsin_chk.sv =====
module fsin_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sine_bits
);
   import fsin_pkg::*;

   // items taken in but not yet handed out
   logic [7:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 8'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sine_bits))
      else $error("response changed before transfer");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("response without an outstanding request");

   a_nan_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine_bits[30:23] != 8'hFF || rsp_sine_bits == QNAN))
      else $error("infinity or non-canonical NaN on response");

endmodule

bind float32_sine_unit fsin_chk u_fsin_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_sine_bits(rsp_chan.sine_bits)
);
